/* hdl/avcpu_pkg.sv */
`default_nettype none
package avcpu_pkg;

	localparam int unsigned DW = 16;
	localparam int unsigned DIV_CW = $clog2(DW + 1);
	localparam logic [DW-1:0] NO_LIMIT = 16'hffff;
	localparam logic [4:0] SOCK_SAT = 5'd31;

	typedef enum logic [1:0] {
		MODE_CPU    = 2'd0,
		MODE_MEM    = 2'd1,
		MODE_CORE   = 2'd2,
		MODE_SOCKET = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE          = 3'd0,
		REG_MAX_SOCKETS   = 3'd1,
		REG_MAX_CORES     = 3'd2,
		REG_MAX_THREADS   = 3'd3,
		REG_MIN_SOCKETS   = 3'd4,
		REG_MIN_CORES     = 3'd5,
		REG_CPUS_PER_TASK = 3'd6,
		REG_NODE_TASK_CAP = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_HEADER = 1'b0,
		OP_SOCKET = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HDIV,
		ST_F1,
		ST_F2,
		ST_F3,
		ST_F4,
		ST_FDIV,
		ST_F5,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] node_cpus;
		logic [4:0]  node_sockets;
		logic [7:0]  node_cores;
		logic [7:0]  node_threads;
		logic [15:0] socket_task_cap;
		logic [15:0] core_task_cap;
		logic [7:0]  socket_used_cores;
		logic        last_item;
	} item_t;

	typedef struct packed {
		logic [15:0] avail_count;
		logic [15:0] free_cpus;
		logic [4:0]  usable_sockets;
		logic [7:0]  usable_cores;
		logic [7:0]  usable_threads;
		logic        underflow;
	} result_t;

	typedef struct packed {
		logic take;
		logic hdr_div;
		logic sock_wr;
		logic f1;
		logic f2;
		logic f3;
		logic f4;
		logic f5;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic last;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

/* hdl/avcpu_ifs.sv */
`default_nettype none
interface avcpu_item_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] node_cpus;
	logic [4:0]  node_sockets;
	logic [7:0]  node_cores;
	logic [7:0]  node_threads;
	logic [15:0] socket_task_cap;
	logic [15:0] core_task_cap;
	logic [7:0]  socket_used_cores;
	logic        last_item;

	modport source (output valid, opcode, node_cpus, node_sockets, node_cores, node_threads,
		socket_task_cap, core_task_cap, socket_used_cores, last_item, input ready);
	modport sink (input valid, opcode, node_cpus, node_sockets, node_cores, node_threads,
		socket_task_cap, core_task_cap, socket_used_cores, last_item, output ready);
endinterface

interface avcpu_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] avail_count;
	logic [15:0] free_cpus;
	logic [4:0]  usable_sockets;
	logic [7:0]  usable_cores;
	logic [7:0]  usable_threads;
	logic        underflow;

	modport source (output valid, avail_count, free_cpus, usable_sockets, usable_cores,
		usable_threads, underflow, input ready);
	modport sink (input valid, avail_count, free_cpus, usable_sockets, usable_cores,
		usable_threads, underflow, output ready);
endinterface
`default_nettype wire

/* hdl/available_cpu_count_core.sv */
`default_nettype none
// Available-CPU counter for one node. Send a header transfer (opcode 0) with the
// node topology, then one socket transfer (opcode 1) per socket; the transfer with
// last_item set yields one result. Header and socket transfers are taken back to
// back, but a header with node_sockets zero first runs the serial divide for the
// socket count and takes no transfer meanwhile. The final transfer adds four
// compute steps, the serial divide by cpus per task, one multiply step and the
// output load, plus any wait while an earlier result still waits on result.ready.
// A final header that needs the socket divide takes both. Configuration writes
// (cfg_wen, cfg_index, cfg_wdata) must happen while the block is idle.
module available_cpu_count_core
	import avcpu_pkg::*;
#(
	parameter int unsigned MAX_SOCKETS = 16
)(
	input  wire logic          clk,
	input  wire logic          arst_n,
	avcpu_item_if.sink         item,
	avcpu_result_if.source     result,
	input  wire logic          cfg_wen,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [DW-1:0] cfg_wdata
);

	item_t   item_d;
	result_t res;
	cmd_t    cmd;
	sts_t    sts;
	logic    rdy, res_valid;

	assign item_d.opcode            = item.opcode;
	assign item_d.node_cpus         = item.node_cpus;
	assign item_d.node_sockets      = item.node_sockets;
	assign item_d.node_cores        = item.node_cores;
	assign item_d.node_threads      = item.node_threads;
	assign item_d.socket_task_cap   = item.socket_task_cap;
	assign item_d.core_task_cap     = item.core_task_cap;
	assign item_d.socket_used_cores = item.socket_used_cores;
	assign item_d.last_item         = item.last_item;

	avcpu_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.sts        (sts),
		.item_ready (rdy),
		.cmd        (cmd)
	);

	avcpu_dp #(.MAX_SOCKETS(MAX_SOCKETS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item_d),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.res_ready (result.ready),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

	assign item.ready            = rdy;
	assign result.valid          = res_valid;
	assign result.avail_count    = res.avail_count;
	assign result.free_cpus      = res.free_cpus;
	assign result.usable_sockets = res.usable_sockets;
	assign result.usable_cores   = res.usable_cores;
	assign result.usable_threads = res.usable_threads;
	assign result.underflow      = res.underflow;

	a_simple_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && !item.last_item &&
		!(item.opcode == OP_HEADER && item.node_sockets == '0) |=> item.ready)
		else $error("input not ready after a plain transfer");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.last_item |=> !item.ready)
		else $error("input ready while a result is being computed");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!item.ready))
		else $error("result loaded while input was ready");

endmodule
`default_nettype wire

/* hdl/avcpu_div.sv */
`default_nettype none
module avcpu_div
	import avcpu_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [DW-1:0] quot,
	output logic               done
);

	logic [DW-1:0]     rem_q, quo_q, dvs_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DW:0]       trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quot = quo_q;
	assign done = cnt_q == '0;

endmodule
`default_nettype wire

/* hdl/avcpu_ctrl.sv */
`default_nettype none
module avcpu_ctrl
	import avcpu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire sts_t sts,
	output logic      item_ready,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (sts.need_div) state_d = ST_HDIV;
					else if (sts.last) state_d = ST_F1;
				end
			end
			ST_HDIV: begin
				if (sts.div_done) state_d = last_q ? ST_F1 : ST_IDLE;
			end
			ST_F1: state_d = ST_F2;
			ST_F2: state_d = ST_F3;
			ST_F3: state_d = ST_F4;
			ST_F4: state_d = ST_FDIV;
			ST_FDIV: begin
				if (sts.div_done) state_d = ST_F5;
			end
			ST_F5: state_d = ST_OUT;
			ST_OUT: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready  = state_q == ST_IDLE;
		cmd.take    = item_ready && item_valid;
		cmd.hdr_div = cmd.take && sts.need_div;
		cmd.sock_wr = state_q == ST_HDIV && sts.div_done;
		cmd.f1      = state_q == ST_F1;
		cmd.f2      = state_q == ST_F2;
		cmd.f3      = state_q == ST_F3;
		cmd.f4      = state_q == ST_F4;
		cmd.f5      = state_q == ST_F5;
		cmd.load    = state_q == ST_OUT && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take) last_q <= sts.last;
		end
	end

endmodule
`default_nettype wire

/* hdl/avcpu_dp.sv */
`default_nettype none
module avcpu_dp
	import avcpu_pkg::*;
#(
	parameter int unsigned MAX_SOCKETS = 16
)(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cmd_t          cmd,
	input  wire item_t         item,
	input  wire logic          cfg_wen,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [DW-1:0] cfg_wdata,
	input  wire logic          res_ready,
	output sts_t               sts,
	output logic               res_valid,
	output result_t            res
);

	localparam int unsigned CW = $clog2(MAX_SOCKETS + 1);

	mode_t         mode_q;
	logic [DW-1:0] max_sock_q, max_cores_q, max_thr_q, min_sock_q, min_cores_q;
	logic [DW-1:0] cpt_cfg_q, node_cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CPU;
			max_sock_q  <= NO_LIMIT;
			max_cores_q <= NO_LIMIT;
			max_thr_q   <= NO_LIMIT;
			min_sock_q  <= '0;
			min_cores_q <= '0;
			cpt_cfg_q   <= 16'd1;
			node_cap_q  <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:          mode_q      <= mode_t'(cfg_wdata[1:0]);
				REG_MAX_SOCKETS:   max_sock_q  <= cfg_wdata;
				REG_MAX_CORES:     max_cores_q <= cfg_wdata;
				REG_MAX_THREADS:   max_thr_q   <= cfg_wdata;
				REG_MIN_SOCKETS:   min_sock_q  <= cfg_wdata;
				REG_MIN_CORES:     min_cores_q <= cfg_wdata;
				REG_CPUS_PER_TASK: cpt_cfg_q   <= cfg_wdata;
				REG_NODE_TASK_CAP: node_cap_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [DW-1:0] cpt;
	assign cpt = (cpt_cfg_q != '0) ? cpt_cfg_q : 16'd1;

	logic [DW-1:0] hw_cpus_q, hw_sockets_q, sock_cap_q, core_cap_q;
	logic [7:0]    hw_cores_q, hw_threads_q;
	logic [DW-1:0] used_sum_q, free_sum_q;
	logic [CW-1:0] busy_q, entry_q;

	logic [7:0]    in_cores, in_threads;
	logic          hdr, slot_ok;
	logic [8:0]    core_left;
	logic [DW-1:0] sock_free;
	assign in_cores   = (item.node_cores != '0) ? item.node_cores : 8'd1;
	assign in_threads = (item.node_threads != '0) ? item.node_threads : 8'd1;
	assign hdr        = item.opcode == OP_HEADER;
	assign slot_ok    = (DW'(entry_q) < hw_sockets_q) && (entry_q < CW'(MAX_SOCKETS));
	assign core_left  = {1'b0, hw_cores_q} - {1'b0, item.socket_used_cores};

	always_comb begin
		if (core_left[8] || min_cores_q > DW'(core_left[7:0])) sock_free = '0;
		else sock_free = DW'(core_left[7:0]) * DW'(hw_threads_q);
	end

	logic          div_start, div_done;
	logic [DW-1:0] div_a, div_b, quot;
	logic [DW-1:0] cpus_fin;

	assign div_start = cmd.hdr_div || cmd.f4;
	assign div_a     = cmd.f4 ? cpus_fin : item.node_cpus;
	assign div_b     = cmd.f4 ? cpt : DW'(in_cores) * DW'(in_threads);

	avcpu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quot     (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_cpus_q    <= '0;
			hw_sockets_q <= '0;
			hw_cores_q   <= '0;
			hw_threads_q <= '0;
			sock_cap_q   <= '0;
			core_cap_q   <= '0;
			used_sum_q   <= '0;
			free_sum_q   <= '0;
			busy_q       <= '0;
			entry_q      <= '0;
		end else if (cmd.sock_wr) begin
			hw_sockets_q <= quot;
		end else if (cmd.take && hdr) begin
			hw_cpus_q    <= item.node_cpus;
			hw_cores_q   <= in_cores;
			hw_threads_q <= in_threads;
			if (item.node_sockets != '0) hw_sockets_q <= DW'(item.node_sockets);
			sock_cap_q   <= item.socket_task_cap;
			core_cap_q   <= item.core_task_cap;
			used_sum_q   <= '0;
			free_sum_q   <= '0;
			busy_q       <= '0;
			entry_q      <= '0;
		end else if (cmd.take && slot_ok) begin
			used_sum_q <= used_sum_q + DW'(item.socket_used_cores);
			free_sum_q <= free_sum_q + sock_free;
			if (item.socket_used_cores != '0) busy_q <= busy_q + 1'b1;
			entry_q <= entry_q + 1'b1;
		end
	end

	assign sts.need_div = hdr && item.node_sockets == '0;
	assign sts.last     = item.last_item;
	assign sts.div_done = div_done;

	// finish sequence
	logic [DW-1:0] alloc_q, sf0_q, rest_q, sock_q;
	logic [7:0]    cores_q, thr_q, nt_q;
	logic          ufs_q, uf_q;
	logic [DW-1:0] cpus_q, rprod_q, per_q, maxav_q, mprod_q, m_q, aprod_q, mc_q;

	logic [DW-1:0] sock_sub, sock_c;
	logic [7:0]    cores_c, thr_c;
	logic          ufs_c;
	always_comb begin
		ufs_c    = 1'b0;
		sock_sub = hw_sockets_q;
		if (mode_q == MODE_SOCKET) begin
			if (hw_sockets_q >= DW'(busy_q)) sock_sub = hw_sockets_q - DW'(busy_q);
			else begin
				sock_sub = '0;
				ufs_c    = 1'b1;
			end
		end
		if (mode_q == MODE_CORE || mode_q == MODE_SOCKET) begin
			sock_c  = (max_sock_q < sock_sub) ? max_sock_q : sock_sub;
			cores_c = (max_cores_q < DW'(hw_cores_q)) ? max_cores_q[7:0] : hw_cores_q;
			thr_c   = (max_thr_q < DW'(hw_threads_q)) ? max_thr_q[7:0] : hw_threads_q;
		end else begin
			sock_c  = hw_sockets_q;
			cores_c = hw_cores_q;
			thr_c   = hw_threads_q;
		end
	end

	logic [DW-1:0] per2, m_c;
	logic          minfail;
	assign per2    = (sock_cap_q != '0 && sock_cap_q < per_q) ? sock_cap_q : per_q;
	assign minfail = min_sock_q > sock_q;

	always_comb begin
		unique case (mode_q)
			MODE_CPU, MODE_MEM: m_c = cpus_q;
			MODE_CORE:          m_c = minfail ? '0 : ((mprod_q < maxav_q) ? mprod_q : maxav_q);
			MODE_SOCKET:        m_c = mprod_q;
			default:            m_c = cpus_q;
		endcase
		if (node_cap_q != '0 && node_cap_q < m_c) m_c = node_cap_q;
		cpus_fin = ((mode_q == MODE_CORE || mode_q == MODE_SOCKET) && minfail) ? '0 : cpus_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.f1) begin
			alloc_q <= used_sum_q * DW'(hw_threads_q);
			sf0_q   <= (min_cores_q > DW'(hw_cores_q)) ? '0
				: DW'(hw_cores_q) * DW'(hw_threads_q);
			rest_q  <= hw_sockets_q - DW'(entry_q);
			sock_q  <= sock_c;
			cores_q <= cores_c;
			thr_q   <= thr_c;
			nt_q    <= (core_cap_q != '0 && core_cap_q < DW'(thr_c)) ? core_cap_q[7:0] : thr_c;
			ufs_q   <= ufs_c;
		end
		if (cmd.f2) begin
			if (mode_q == MODE_MEM) begin
				cpus_q <= hw_cpus_q;
				uf_q   <= ufs_q;
			end else if (hw_cpus_q >= alloc_q) begin
				cpus_q <= hw_cpus_q - alloc_q;
				uf_q   <= ufs_q;
			end else begin
				cpus_q <= '0;
				uf_q   <= 1'b1;
			end
			rprod_q <= DW'(rest_q * sf0_q);
			per_q   <= (mode_q == MODE_CORE && min_cores_q > DW'(cores_q)) ? '0
				: DW'(cores_q) * DW'(nt_q);
		end
		if (cmd.f3) begin
			maxav_q <= (mode_q == MODE_CORE && used_sum_q != '0) ? free_sum_q + rprod_q : NO_LIMIT;
			mprod_q <= DW'(sock_q * per2);
		end
		if (cmd.f4) begin
			m_q    <= m_c;
			cpus_q <= cpus_fin;
		end
		if (cmd.f5) begin
			aprod_q <= DW'(quot * cpt);
			mc_q    <= DW'(m_q * cpt);
		end
	end

	logic out_valid_q;
	assign sts.out_busy = out_valid_q && !res_ready;
	assign res_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (res_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res.avail_count    <= (aprod_q < mc_q) ? aprod_q : mc_q;
			res.free_cpus      <= cpus_q;
			res.usable_sockets <= (sock_q > DW'(SOCK_SAT)) ? SOCK_SAT : sock_q[4:0];
			res.usable_cores   <= cores_q;
			res.usable_threads <= thr_q;
			res.underflow      <= uf_q;
		end
	end

endmodule
`default_nettype wire

/* dv/avcpu_checker.sv */
module avcpu_checker
	import avcpu_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	avcpu_item_if              item,
	avcpu_result_if            result,
	input  wire logic          cfg_wen,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [DW-1:0] cfg_wdata,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);

	localparam int unsigned MAX_SOCK = 16;

	mode_t       acct_mode;
	int unsigned lim_sockets, lim_cores, lim_threads, need_sockets, need_cores;
	int unsigned task_cpus, node_cap;

	int unsigned node_cpus, node_sockets, node_cores, node_threads;
	int unsigned sock_cap, core_cap;
	int unsigned used_cores, busy_sockets, free_cpus, sockets_seen;

	result_t expected_q[$];

	function automatic int unsigned min_u(int unsigned a, int unsigned b);
		return a < b ? a : b;
	endfunction

	function automatic int unsigned free_on_socket(int unsigned used);
		if (used > node_cores)
			return 0;
		if (need_cores > node_cores - used)
			return 0;
		return ((node_cores - used) * node_threads) & 16'hffff;
	endfunction

	function automatic result_t node_summary();
		int unsigned cpus, socks, cores, thr, cpt, alloc, max_avail, cpu_cap, per, nt, avail;
		logic uf;
		result_t r;
		cpus = node_cpus;
		socks = node_sockets;
		cores = node_cores;
		thr = node_threads;
		cpt = task_cpus != 0 ? task_cpus : 1;
		alloc = (used_cores * node_threads) & 16'hffff;
		max_avail = NO_LIMIT;
		cpu_cap = 0;
		uf = 1'b0;
		if (acct_mode == MODE_CPU || acct_mode == MODE_MEM) begin
			if (acct_mode == MODE_CPU) begin
				if (cpus >= alloc) cpus -= alloc;
				else begin
					cpus = 0;
					uf = 1'b1;
				end
			end
			cpu_cap = cpus;
			if (node_cap != 0) cpu_cap = min_u(cpu_cap, node_cap);
		end else if (acct_mode == MODE_CORE) begin
			if (cpus >= alloc) cpus -= alloc;
			else begin
				cpus = 0;
				uf = 1'b1;
			end
			if (used_cores != 0)
				max_avail = (free_cpus + ((node_sockets - sockets_seen) & 16'hffff)
					* free_on_socket(0)) & 16'hffff;
			socks = min_u(socks, lim_sockets);
			thr = min_u(thr, lim_threads);
			cores = min_u(cores, lim_cores);
			if (need_sockets > socks) begin
				cpus = 0;
			end else begin
				per = 0;
				if (need_cores <= cores) begin
					nt = thr;
					if (core_cap != 0) nt = min_u(nt, core_cap);
					per = cores * nt;
				end
				if (sock_cap != 0) per = min_u(per, sock_cap);
				cpu_cap = min_u((socks * per) & 16'hffff, max_avail);
			end
			cpu_cap = min_u(cpu_cap, max_avail);
			if (node_cap != 0) cpu_cap = min_u(cpu_cap, node_cap);
		end else begin
			if (socks >= busy_sockets) socks -= busy_sockets;
			else begin
				socks = 0;
				uf = 1'b1;
			end
			if (cpus >= alloc) cpus -= alloc;
			else begin
				cpus = 0;
				uf = 1'b1;
			end
			socks = min_u(socks, lim_sockets);
			cores = min_u(cores, lim_cores);
			thr = min_u(thr, lim_threads);
			if (need_sockets > socks) cpus = 0;
			cpu_cap = thr;
			if (core_cap != 0) cpu_cap = min_u(cpu_cap, core_cap);
			cpu_cap = (cpu_cap * cores) & 16'hffff;
			if (sock_cap != 0) cpu_cap = min_u(cpu_cap, sock_cap);
			cpu_cap = (cpu_cap * socks) & 16'hffff;
			if (node_cap != 0) cpu_cap = min_u(cpu_cap, node_cap);
			cpu_cap = min_u(cpu_cap, max_avail);
		end
		cpu_cap = (cpu_cap * cpt) & 16'hffff;
		avail = min_u((cpus / cpt) * cpt, cpu_cap);
		r.avail_count = avail[15:0];
		r.free_cpus = cpus[15:0];
		r.usable_sockets = socks > 31 ? SOCK_SAT : socks[4:0];
		r.usable_cores = cores[7:0];
		r.usable_threads = thr[7:0];
		r.underflow = uf;
		return r;
	endfunction

	task automatic absorb_item(item_t it);
		if (opcode_t'(it.opcode) == OP_HEADER) begin
			node_cpus = 32'(it.node_cpus);
			node_threads = it.node_threads != 0 ? 32'(it.node_threads) : 1;
			node_cores = it.node_cores != 0 ? 32'(it.node_cores) : 1;
			node_sockets = it.node_sockets != 0 ? 32'(it.node_sockets)
				: node_cpus / node_cores / node_threads;
			sock_cap = 32'(it.socket_task_cap);
			core_cap = 32'(it.core_task_cap);
			used_cores = 0;
			busy_sockets = 0;
			free_cpus = 0;
			sockets_seen = 0;
		end else if (sockets_seen < node_sockets && sockets_seen < MAX_SOCK) begin
			used_cores = (used_cores + 32'(it.socket_used_cores)) & 16'hffff;
			if (it.socket_used_cores != 0) busy_sockets++;
			free_cpus = (free_cpus + free_on_socket(32'(it.socket_used_cores))) & 16'hffff;
			sockets_seen++;
		end
		if (it.last_item)
			expected_q.push_back(node_summary());
	endtask

	task automatic check_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			$display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp, act);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t   it;
		result_t got, exp;
		if (!arst_n) begin
			acct_mode = MODE_CPU;
			lim_sockets = NO_LIMIT;
			lim_cores = NO_LIMIT;
			lim_threads = NO_LIMIT;
			need_sockets = 0;
			need_cores = 0;
			task_cpus = 1;
			node_cap = 0;
			node_cpus = 0;
			node_sockets = 0;
			node_cores = 0;
			node_threads = 0;
			sock_cap = 0;
			core_cap = 0;
			used_cores = 0;
			busy_sockets = 0;
			free_cpus = 0;
			sockets_seen = 0;
		end else begin
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_index))
					REG_MODE:          acct_mode = mode_t'(cfg_wdata[1:0]);
					REG_MAX_SOCKETS:   lim_sockets = 32'(cfg_wdata);
					REG_MAX_CORES:     lim_cores = 32'(cfg_wdata);
					REG_MAX_THREADS:   lim_threads = 32'(cfg_wdata);
					REG_MIN_SOCKETS:   need_sockets = 32'(cfg_wdata);
					REG_MIN_CORES:     need_cores = 32'(cfg_wdata);
					REG_CPUS_PER_TASK: task_cpus = 32'(cfg_wdata);
					REG_NODE_TASK_CAP: node_cap = 32'(cfg_wdata);
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				it.opcode = item.opcode;
				it.node_cpus = item.node_cpus;
				it.node_sockets = item.node_sockets;
				it.node_cores = item.node_cores;
				it.node_threads = item.node_threads;
				it.socket_task_cap = item.socket_task_cap;
				it.core_task_cap = item.core_task_cap;
				it.socket_used_cores = item.socket_used_cores;
				it.last_item = item.last_item;
				absorb_item(it);
			end
			if (result.valid && result.ready) begin
				got.avail_count = result.avail_count;
				got.free_cpus = result.free_cpus;
				got.usable_sockets = result.usable_sockets;
				got.usable_cores = result.usable_cores;
				got.usable_threads = result.usable_threads;
				got.underflow = result.underflow;
				result_count++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result transfer avail %0d free %0d", $time,
						got.avail_count, got.free_cpus);
					fail_count++;
				end else begin
					exp = expected_q.pop_front();
					check_field("avail_count", exp.avail_count, got.avail_count);
					check_field("free_cpus", exp.free_cpus, got.free_cpus);
					check_field("usable_sockets", exp.usable_sockets, got.usable_sockets);
					check_field("usable_cores", exp.usable_cores, got.usable_cores);
					check_field("usable_threads", exp.usable_threads, got.usable_threads);
					check_field("underflow", exp.underflow, got.underflow);
				end
			end
			pending = expected_q.size();
		end
	end

	initial begin
		fail_count = 0;
		result_count = 0;
		pending = 0;
	end

endmodule

/* dv/testbench.sv */
module testbench;
	import avcpu_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN = 40;

	logic          clk;
	logic          arst_n;
	logic          cfg_wen;
	logic [2:0]    cfg_index;
	logic [DW-1:0] cfg_wdata;
	int            fail_count, pending, result_count;
	int            item_count, cycles;
	bit            ready_steady;
	int            stall_left;

	avcpu_item_if   item_ch();
	avcpu_result_if result_ch();

	available_cpu_count_core dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	avcpu_checker u_chk (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// result-side back pressure
	always @(posedge clk) begin
		if (ready_steady) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = $urandom_range(0, 19) == 0 ? $urandom_range(20, 60)
					: $urandom_range(1, 3);
		end
	end

	function automatic int unsigned pick16();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hffff;
			2: return $urandom_range(1, 8);
			3: return $urandom_range(1, 64);
			default: return $urandom_range(0, 16'hffff);
		endcase
	endfunction

	task automatic send(item_t it);
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.node_cpus <= it.node_cpus;
		item_ch.node_sockets <= it.node_sockets;
		item_ch.node_cores <= it.node_cores;
		item_ch.node_threads <= it.node_threads;
		item_ch.socket_task_cap <= it.socket_task_cap;
		item_ch.core_task_cap <= it.core_task_cap;
		item_ch.socket_used_cores <= it.socket_used_cores;
		item_ch.last_item <= it.last_item;
		do @(posedge clk); while (!item_ch.ready);
		item_count++;
		gap = 0;
		if (!ready_steady && $urandom_range(0, 2) == 0)
			gap = $urandom_range(0, 15) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 3);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[15:0];
		@(posedge clk);
	endtask

	task automatic end_writes();
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.opcode = 1'($urandom_range(0, 1));
		it.node_cpus = 16'($urandom_range(0, 16'hffff));
		it.node_sockets = 5'($urandom_range(0, 16));
		it.node_cores = 8'($urandom_range(0, 255));
		it.node_threads = 8'($urandom_range(0, 255));
		it.socket_task_cap = 16'($urandom_range(0, 16'hffff));
		it.core_task_cap = 16'($urandom_range(0, 16'hffff));
		it.socket_used_cores = 8'($urandom_range(0, 255));
		it.last_item = 1'b0;
		return it;
	endfunction

	task automatic send_node(int max_items);
		item_t hdr, it;
		int sockets, cores, n;
		hdr = rand_item();
		hdr.opcode = OP_HEADER;
		sockets = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 16);
		cores = $urandom_range(0, 7) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 16);
		hdr.node_sockets = 5'(sockets);
		hdr.node_cores = 8'(cores);
		hdr.node_threads = 8'($urandom_range(0, 7) == 0 ? $urandom_range(0, 255)
			: $urandom_range(0, 4));
		if ($urandom_range(0, 1) == 0)
			hdr.node_cpus = 16'((sockets == 0 ? $urandom_range(1, 8) : sockets)
				* (cores == 0 ? 1 : cores) * (hdr.node_threads == 0 ? 1 : hdr.node_threads));
		else
			hdr.node_cpus = 16'(pick16());
		hdr.socket_task_cap = 16'(pick16());
		hdr.core_task_cap = 16'(pick16());
		n = (sockets == 0 ? $urandom_range(0, 6) : sockets) + $urandom_range(0, 4) - 1;
		if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 20);
		if (n < 0) n = 0;
		if (n > max_items - 1) n = max_items - 1;
		hdr.last_item = n == 0;
		send(hdr);
		for (int i = 0; i < n; i++) begin
			it = rand_item();
			it.opcode = OP_SOCKET;
			it.socket_used_cores = 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
				: $urandom_range(0, cores));
			if ($urandom_range(0, 3) == 0) it.socket_used_cores = 0;
			it.last_item = i == n - 1 || $urandom_range(0, 24) == 0;
			send(it);
		end
	endtask

	function automatic int unsigned cfg_value(int unsigned top);
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 16'hffff;
			2: return $urandom_range(0, top);
			default: return $urandom_range(1, 16);
		endcase
	endfunction

	initial begin
		item_t it;
		int left, chunk;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = 1'b0;
		item_ch.node_cpus = '0;
		item_ch.node_sockets = '0;
		item_ch.node_cores = '0;
		item_ch.node_threads = '0;
		item_ch.socket_task_cap = '0;
		item_ch.core_task_cap = '0;
		item_ch.socket_used_cores = '0;
		item_ch.last_item = 1'b0;
		result_ch.ready = 1'b0;
		ready_steady = 1'b1;
		stall_left = 0;
		item_count = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no header yet: reset topology
		it = '0;
		it.opcode = OP_SOCKET;
		it.socket_used_cores = 8'hff;
		it.last_item = 1'b1;
		send(it);
		wait_results();

		// extremes per mode
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_MODE, m);
			end_writes();
			it = '1;
			it.opcode = OP_HEADER;
			it.node_sockets = 16;
			it.last_item = 1'b1;
			send(it);
			it.opcode = OP_SOCKET;
			it.last_item = 1'b0;
			send(it);
			it.socket_used_cores = 0;
			it.last_item = 1'b1;
			send(it);
			it = '0;
			it.opcode = OP_HEADER;
			it.last_item = 1'b0;
			send(it);
			it.opcode = OP_SOCKET;
			it.socket_used_cores = 8'd1;
			it.last_item = 1'b1;
			send(it);
			wait_results();
		end

		left = 1950;
		for (int phase = 0; phase < 12; phase++) begin
			write_reg(REG_MODE, phase % 4);
			if (phase >= 4 && phase < 6) begin
				write_reg(REG_MAX_SOCKETS, phase == 4 ? 0 : 16'hffff);
				write_reg(REG_MAX_CORES, phase == 4 ? 0 : 16'hffff);
				write_reg(REG_MAX_THREADS, phase == 4 ? 0 : 16'hffff);
				write_reg(REG_MIN_SOCKETS, phase == 4 ? 16'hffff : 0);
				write_reg(REG_MIN_CORES, phase == 4 ? 16'hffff : 0);
				write_reg(REG_CPUS_PER_TASK, phase == 4 ? 0 : 16'hffff);
				write_reg(REG_NODE_TASK_CAP, phase == 4 ? 16'hffff : 0);
			end else if (phase >= 6) begin
				write_reg(REG_MAX_SOCKETS, cfg_value(16));
				write_reg(REG_MAX_CORES, cfg_value(255));
				write_reg(REG_MAX_THREADS, cfg_value(8));
				write_reg(REG_MIN_SOCKETS, $urandom_range(0, 1) ? 0 : cfg_value(8));
				write_reg(REG_MIN_CORES, $urandom_range(0, 1) ? 0 : cfg_value(8));
				write_reg(REG_CPUS_PER_TASK, cfg_value(8));
				write_reg(REG_NODE_TASK_CAP, cfg_value(256));
			end
			end_writes();
			ready_steady = phase % 5 == 2;
			chunk = left / (12 - phase);
			while (chunk > 0) begin
				if ($urandom_range(0, 19) == 0) begin
					it = rand_item();
					it.last_item = 1'($urandom_range(0, 1));
					send(it);
					chunk--;
				end else begin
					left = item_count;
					send_node(chunk);
					chunk -= item_count - left;
				end
				if ($urandom_range(0, 29) == 0)
					wait_results();
			end
			left = 1950 - (item_count - 21);
			wait_results();
		end

		$display("Sent %0d item transfers over 4 accounting modes and 12 register settings;",
			item_count);
		$display("checked %0d result transfers.", result_count);
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
